@@ rtl/core/box_blur_3x3_stream_assert.svh @@
// Assertion macros for the box blur RTL.
// Expects signals named clk and rst in the including module's scope.
`ifndef BOX_BLUR_3X3_STREAM_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_ASSERT_SVH

// Checked on every clock outside reset.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock, reset included.
`define BB3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/bb3_pkg.sv @@
// Shared types and constants for the 3x3 box blur stream.
// No dependencies; imported by bb3_avg and box_blur_3x3_stream.
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Configuration port
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Pixel and arithmetic widths
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int NUM_W  = SUM_W + 1;
  localparam int RCP_W  = 18;
  localparam int PROD_W = NUM_W + RCP_W;

  // Rounded mean (2*sum + n) / (2*n) as a multiply by ceil(2^20 / (2*n)).
  localparam int RECIP_SHIFT = 20;
  localparam logic [RCP_W-1:0] RECIP_4 = RCP_W'(131072);
  localparam logic [RCP_W-1:0] RECIP_6 = RCP_W'(87382);
  localparam logic [RCP_W-1:0] RECIP_9 = RCP_W'(58255);

  // Results one input may cause, in issue order
  localparam int NUM_EMIT      = 4;
  localparam int EMIT_PREV     = 0;  // previous row, column c-1
  localparam int EMIT_PREV_END = 1;  // previous row, last column
  localparam int EMIT_CUR      = 2;  // last row, column c-1
  localparam int EMIT_CUR_END  = 3;  // last row, last column

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CNT_4,
    CNT_6,
    CNT_9
  } ncount_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0] col_t;  // index 0: row r-2, 1: row r-1, 2: row r

  // One averaging job: window columns c-2, c-1, c and which edge parts count.
  typedef struct packed {
    col_t [2:0] cols;
    logic       use_c0;
    logic       use_r0;
    logic       last;
    logic       eof;
  } avg_job_t;

endpackage

`default_nettype wire

@@ rtl/core/bb3_avg.sv @@
// Pipelined window averager: masked 3x3 sum, reciprocal multiply, output register.
// Depends on bb3_pkg.
`default_nettype none

module bb3_avg import bb3_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  avg_job_t        job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CH_W-1:0] out_red,
  output logic [CH_W-1:0] out_green,
  output logic [CH_W-1:0] out_blue,
  output logic            last_of_run,
  output logic            end_of_frame
);

  logic [SUM_W-1:0]       col_sum [3];
  logic [2:0][SUM_W-1:0]  sum_next;
  ncount_t                cnt_next;

  logic                   x_valid;
  logic [2:0][SUM_W-1:0]  x_sum;
  ncount_t                x_cnt;
  logic                   x_last;
  logic                   x_eof;

  logic [NUM_W-1:0]       x_n;
  logic [RCP_W-1:0]       x_recip;
  logic [2:0][PROD_W-1:0] prod_next;

  logic                   y_valid;
  logic [2:0][PROD_W-1:0] y_prod;
  logic                   y_last;
  logic                   y_eof;

  logic                   z_valid;
  logic [2:0][CH_W-1:0]   z_rgb;
  logic                   z_last;
  logic                   z_eof;

  logic                   ld_x;
  logic                   ld_y;
  logic                   ld_z;

  // Each stage loads when empty or when it empties this cycle.
  assign ld_z      = !z_valid || out_ready;
  assign ld_y      = !y_valid || ld_z;
  assign ld_x      = !x_valid || ld_y;
  assign job_ready = ld_x;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int cc = 0; cc < 3; cc++) begin
        col_sum[cc] = SUM_W'(job.cols[cc][1][ch*CH_W +: CH_W])
                    + SUM_W'(job.cols[cc][2][ch*CH_W +: CH_W]);
        if (job.use_r0) begin
          col_sum[cc] = col_sum[cc] + SUM_W'(job.cols[cc][0][ch*CH_W +: CH_W]);
        end
      end
      sum_next[ch] = col_sum[1] + col_sum[2];
      if (job.use_c0) begin
        sum_next[ch] = sum_next[ch] + col_sum[0];
      end
    end
  end

  always_comb begin
    case ({job.use_c0, job.use_r0})
      2'b11:   cnt_next = CNT_9;
      2'b00:   cnt_next = CNT_4;
      default: cnt_next = CNT_6;
    endcase
  end

  always_comb begin
    case (x_cnt)
      CNT_4: begin
        x_n     = NUM_W'(4);
        x_recip = RECIP_4;
      end
      CNT_6: begin
        x_n     = NUM_W'(6);
        x_recip = RECIP_6;
      end
      CNT_9: begin
        x_n     = NUM_W'(9);
        x_recip = RECIP_9;
      end
      default: begin
        x_n     = NUM_W'(4);
        x_recip = RECIP_4;
      end
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      prod_next[ch] = PROD_W'({x_sum[ch], 1'b0} + x_n) * PROD_W'(x_recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      y_valid <= 1'b0;
      z_valid <= 1'b0;
    end else begin
      if (ld_x) begin
        x_valid <= job_valid;
      end
      if (ld_y) begin
        y_valid <= x_valid;
      end
      if (ld_z) begin
        z_valid <= y_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_x && job_valid) begin
      x_sum  <= sum_next;
      x_cnt  <= cnt_next;
      x_last <= job.last;
      x_eof  <= job.eof;
    end
    if (ld_y && x_valid) begin
      y_prod <= prod_next;
      y_last <= x_last;
      y_eof  <= x_eof;
    end
    if (ld_z && y_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        z_rgb[ch] <= y_prod[ch][RECIP_SHIFT +: CH_W];
      end
      z_last <= y_last;
      z_eof  <= y_eof;
    end
  end

  assign out_valid    = z_valid;
  assign out_red      = z_rgb[0];
  assign out_green    = z_rgb[1];
  assign out_blue     = z_rgb[2];
  assign last_of_run  = z_last;
  assign end_of_frame = z_eof;

endmodule

`default_nettype wire

@@ rtl/core/box_blur_3x3_stream.sv @@
// Top level of the 3x3 box blur stream: config registers, line memory, sequencer.
// Depends on bb3_pkg, bb3_avg and box_blur_3x3_stream_assert.svh.
//
// Usage: write frame_width (0x0) and frame_height (0x4) over the APB port while the
// block is idle; either write restarts the frame at row 0, column 0. Sizes below 2
// act as 2, above 1024 x 4096 act as the maximum. Feed RGB pixels in raster order on
// in_valid/in_ready; each transfer on out_valid/out_ready carries one blurred pixel,
// the rounded-half-up mean of its in-bounds 3x3 neighborhood.
// Outputs trail the input by one row and one pixel; while the last row arrives both
// final rows are emitted, so that row issues two results per pixel (the last column
// four). last_of_run marks the final result of one input, end_of_frame the bottom
// right pixel.
// Throughput: one pixel per clock on all other rows while the output does not stall,
// except the last column of each row from row 1 on, which issues two results; the
// averager takes one result per cycle unless the output stalls, and one line read and
// one write per pixel keep pace. After the transfer of the pixel that completes its
// neighborhood, a result passes stage 1 line read, sum, multiply, output register.
// A stalled receiver fills the three result stages; input then holds off once stage 1
// has results to issue, until a result leaves. Reset clears control state; the line
// memory is not cleared; entries not yet written in a frame feed only excluded neighbors.
`default_nettype none
`include "box_blur_3x3_stream_assert.svh"

module box_blur_3x3_stream import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Pixel input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  // Result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic              last_of_run,
  output logic              end_of_frame
);

  // Configuration
  logic [FW_W-1:0]       frame_width;
  logic [FH_W-1:0]       frame_height;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic [FW_W-1:0]       w_eff;
  logic [FH_W-1:0]       h_eff;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      h_last;

  // Position of the next input
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic                  at_last_col;
  logic                  at_last_row;
  logic [NUM_EMIT-1:0]   pend_next;
  logic                  accept;

  // Stage 1: item waiting on its line read and issuing its results
  logic                  s1_valid;
  logic [NUM_EMIT-1:0]   s1_pend;
  logic [NUM_EMIT-1:0]   pend_low;
  logic [COL_W-1:0]      s1_col;
  pix_t                  s1_pix;
  logic                  s1_c_ge2;
  logic                  s1_r_ge2;
  logic                  s1_done;

  // Line memory: upper row in the high half, middle row in the low half
  logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]    line_rd;

  // Columns c-2 and c-1 of the window
  col_t                  wc [2];

  avg_job_t              job;
  logic                  job_valid;
  logic                  job_ready;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Clamp sizes into the supported range
  always_comb begin
    if (frame_width < FW_W'(2)) begin
      w_eff = FW_W'(2);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < FH_W'(2)) begin
      h_eff = FH_W'(2);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    w_last = COL_W'(w_eff - FW_W'(1));
    h_last = ROW_W'(h_eff - FH_W'(1));
  end

  // ---------------------------------------------------------------- input side
  assign accept      = in_valid && in_ready;
  assign at_last_col = (col_count == w_last);
  assign at_last_row = (row_count == h_last);

  // Results this input will cause; none on row 0 or, off the last column, column 0
  always_comb begin
    pend_next                = '0;
    pend_next[EMIT_PREV]     = (row_count != '0) && (col_count != '0);
    pend_next[EMIT_PREV_END] = (row_count != '0) && at_last_col;
    pend_next[EMIT_CUR]      = at_last_row && (col_count != '0);
    pend_next[EMIT_CUR_END]  = at_last_row && at_last_col;
  end

  // ---------------------------------------------------------------- stage 1
  // Issue the lowest pending result first
  assign pend_low  = s1_pend & (~s1_pend + NUM_EMIT'(1));
  assign job_valid = s1_valid && (s1_pend != '0);
  assign s1_done   = s1_valid && ((s1_pend == '0) || (job.last && job_ready));
  assign in_ready  = !s1_valid || s1_done;

  always_comb begin
    job.cols[0] = wc[0];
    job.cols[1] = wc[1];
    job.cols[2] = {s1_pix, line_rd[PIX_W-1:0], line_rd[2*PIX_W-1:PIX_W]};
    // Column c-2 counts for the interior outputs once c >= 2
    job.use_c0  = s1_c_ge2 && (pend_low[EMIT_PREV] || pend_low[EMIT_CUR]);
    // Row r-2 counts for the previous-row outputs once r >= 2
    job.use_r0  = s1_r_ge2 && (pend_low[EMIT_PREV] || pend_low[EMIT_PREV_END]);
    job.last    = ((s1_pend & (s1_pend - NUM_EMIT'(1))) == '0);
    job.eof     = pend_low[EMIT_CUR_END];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
      col_count    <= '0;
      row_count    <= '0;
      wc[0]        <= '0;
      wc[1]        <= '0;
      s1_valid     <= 1'b0;
      s1_pend      <= '0;
    end else begin
      if (cfg_wr) begin
        // Any register write restarts the frame
        unique case (cfg_idx)
          REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
          default:          frame_width  <= frame_width;
        endcase
        col_count <= '0;
        row_count <= '0;
        wc[0]     <= '0;
        wc[1]     <= '0;
      end else begin
        if (accept) begin
          if (at_last_col) begin
            col_count <= '0;
            row_count <= at_last_row ? '0 : row_count + ROW_W'(1);
          end else begin
            col_count <= col_count + COL_W'(1);
          end
        end
        if (s1_done) begin
          // Advance the window by one column
          wc[0] <= wc[1];
          wc[1] <= job.cols[2];
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
        s1_pend  <= pend_next;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
        s1_pend  <= '0;
      end else if (job_valid && job_ready) begin
        s1_pend  <= s1_pend & ~pend_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_count;
      s1_pix   <= {blue, green, red};
      s1_c_ge2 <= |col_count[COL_W-1:1];
      s1_r_ge2 <= |row_count[ROW_W-1:1];
    end
  end

  // Read at acceptance, write back when the item leaves stage 1. Consecutive
  // items sit in different columns (width at least 2), so the read and the
  // write of one cycle never meet on one entry; the read data holds while
  // stage 1 stalls because no new read is issued then.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col_count];
    end
    if (s1_done) begin
      line_mem[s1_col] <= {line_rd[PIX_W-1:0], s1_pix};
    end
  end

  // ---------------------------------------------------------------- averager
  bb3_avg u_avg (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

  // ---------------------------------------------------------------- checks
  `BB3_ASSERT(a_eof_is_last, (out_valid && end_of_frame) |-> last_of_run, "end of frame not on last result")
  `BB3_ASSERT(a_pend_shrinks, (job_valid && job_ready && !s1_done) |=> ($countones(s1_pend) == $countones($past(s1_pend)) - 1), "pending results did not drop by one")
  `BB3_ASSERT(a_stall_has_work, !in_ready |-> job_valid, "input held with no result to issue")
  `BB3_ASSERT(a_pos_in_frame, (col_count <= w_last) && (row_count <= h_last), "position outside frame")
  `BB3_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !s1_valid), "pipeline not empty after reset")

endmodule

`default_nettype wire
